FILE: rtl/core/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg: shared constants and types for the shuffled combined LCG
// Generator constants, datapath widths and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package scl_pkg;

  // generator A
  localparam int unsigned MOD_A = 259200;
  localparam int unsigned MUL_A = 7141;
  localparam int unsigned INC_A = 54773;
  // generator B
  localparam int unsigned MOD_B = 134456;
  localparam int unsigned MUL_B = 8121;
  localparam int unsigned INC_B = 28411;
  // generator C (table index)
  localparam int unsigned MOD_C = 243000;
  localparam int unsigned MUL_C = 4561;
  localparam int unsigned INC_C = 51349;

  localparam int unsigned TABLE_DEPTH_DEF = 100;

  // field widths
  localparam int SEED_W = 16;
  localparam int GEN_W  = 18;
  localparam int DEV_W  = 36;

  // modular reduction widths: operand below 2^X_W, reciprocal scaled by 2^X_W
  localparam int X_W = 31;
  localparam int Q_W = 14;
  localparam int R_W = 19;
  localparam int P_W = X_W + Q_W;

  // controller -> datapath commands
  typedef struct packed {
    logic load_seed;   // gen_a from the seed register
    logic commit_a;    // gen_a takes the reduced step
    logic commit_b;
    logic commit_c;
    logic derive_b;    // gen_b from gen_a
    logic derive_c;    // gen_c from gen_a, fill counter cleared
    logic fill_write;  // table entry at fill counter takes the deviate
    logic commit_idx;  // table index register loads
    logic access;      // read old entry, write new deviate
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic fill_last;
  } dp_status_t;

endpackage

FILE: rtl/core/scl_if.sv
// ----------------------------------------------------------------------------
// scl_if: valid/ready channels of the shuffled combined LCG
// Request channel, deviate channel and seed configuration channel.
// ----------------------------------------------------------------------------
interface scl_req_if;
  logic valid;
  logic ready;
  logic draw_request;

  modport source (output valid, output draw_request, input ready);
  modport sink (input valid, input draw_request, output ready);
endinterface

interface scl_dev_if;
  logic                       valid;
  logic                       ready;
  logic [scl_pkg::DEV_W-1:0]  deviate_numerator;

  modport source (output valid, output deviate_numerator, input ready);
  modport sink (input valid, input deviate_numerator, output ready);
endinterface

interface scl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [scl_pkg::SEED_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

FILE: rtl/core/scl_lane.sv
// ----------------------------------------------------------------------------
// scl_lane: constant multiply-add with modular reduction
// Computes (MULT*v + INC) div/mod MODULUS: multiply-add, reciprocal estimate
// and remainder subtract, each registered, then one unregistered correction.
// ----------------------------------------------------------------------------
module scl_lane #(
  parameter int unsigned MULT    = scl_pkg::MUL_A,
  parameter int unsigned INC     = scl_pkg::INC_A,
  parameter int unsigned MODULUS = scl_pkg::MOD_A
) (
  input  logic                       clk,
  input  logic [scl_pkg::GEN_W-1:0]  v,
  output logic [scl_pkg::GEN_W-1:0]  rem,
  output logic [scl_pkg::Q_W-1:0]    quo
);

  // floor(2^X_W / MODULUS): quotient estimate is exact or one low
  localparam longint unsigned RECIP = (64'd1 << scl_pkg::X_W) / MODULUS;

  logic [scl_pkg::X_W-1:0] x;
  logic [scl_pkg::Q_W-1:0] q;
  logic [scl_pkg::R_W-1:0] r;
  logic [scl_pkg::P_W-1:0] prod_q;
  logic [31:0]             diff;
  logic                    over;

  assign prod_q = scl_pkg::P_W'(x) * scl_pkg::P_W'(RECIP);
  assign diff   = 32'(x) - 32'(q) * 32'(MODULUS);

  // step registers
  always_ff @(posedge clk) begin
    x <= scl_pkg::X_W'(MULT) * scl_pkg::X_W'(v) + scl_pkg::X_W'(INC);
    q <= prod_q[scl_pkg::P_W-1:scl_pkg::X_W];
    r <= diff[scl_pkg::R_W-1:0];
  end

  // final correction
  assign over = (r >= scl_pkg::R_W'(MODULUS));
  assign rem  = over ? scl_pkg::GEN_W'(r - scl_pkg::R_W'(MODULUS))
                     : scl_pkg::GEN_W'(r);
  assign quo  = q + scl_pkg::Q_W'(over);

endmodule

FILE: rtl/core/scl_dp.sv
// ----------------------------------------------------------------------------
// scl_dp: datapath of the shuffled combined LCG
// Seed register, three generator states, reduction lanes, deviate
// register, table index, fill counter and the shuffle table memory.
// ----------------------------------------------------------------------------
module scl_dp #(
  parameter int unsigned TABLE_DEPTH = scl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [scl_pkg::SEED_W-1:0]  cfg_seed,
  input  scl_pkg::dp_cmd_t            cmd,
  output scl_pkg::dp_status_t         status,
  output logic [scl_pkg::DEV_W-1:0]   dev_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [scl_pkg::SEED_W-1:0] seed;
  logic [scl_pkg::GEN_W-1:0]  gen_a;
  logic [scl_pkg::GEN_W-1:0]  gen_b;
  logic [scl_pkg::GEN_W-1:0]  gen_c;
  logic [scl_pkg::GEN_W-1:0]  rem_a;
  logic [scl_pkg::GEN_W-1:0]  rem_b;
  logic [scl_pkg::GEN_W-1:0]  rem_c;
  logic [scl_pkg::Q_W-1:0]    quo_i;
  logic [scl_pkg::GEN_W:0]    start;
  logic [scl_pkg::DEV_W-1:0]  dev;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           fill_cnt;
  logic [IDX_W-1:0]           wr_addr;
  logic                       wr_en;
  logic [scl_pkg::DEV_W-1:0]  mem [TABLE_DEPTH];

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_seed;
    end
  end

  // start value: (INC_A - seed) wrapped into 0..MOD_A-1
  assign start = (seed <= scl_pkg::SEED_W'(scl_pkg::INC_A))
               ? (19'(scl_pkg::INC_A) - 19'(seed))
               : (19'(scl_pkg::MOD_A + scl_pkg::INC_A) - 19'(seed));

  // reduction lanes
  scl_lane #(.MULT(scl_pkg::MUL_A), .INC(scl_pkg::INC_A), .MODULUS(scl_pkg::MOD_A))
    u_lane_a (.clk(clk), .v(gen_a), .rem(rem_a), .quo());
  scl_lane #(.MULT(scl_pkg::MUL_B), .INC(scl_pkg::INC_B), .MODULUS(scl_pkg::MOD_B))
    u_lane_b (.clk(clk), .v(gen_b), .rem(rem_b), .quo());
  scl_lane #(.MULT(scl_pkg::MUL_C), .INC(scl_pkg::INC_C), .MODULUS(scl_pkg::MOD_C))
    u_lane_c (.clk(clk), .v(gen_c), .rem(rem_c), .quo());
  // index = floor(TABLE_DEPTH * gen_c / MOD_C)
  scl_lane #(.MULT(TABLE_DEPTH), .INC(0), .MODULUS(scl_pkg::MOD_C))
    u_lane_i (.clk(clk), .v(gen_c), .rem(), .quo(quo_i));

  // generator states
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_a <= '0;
      gen_b <= '0;
      gen_c <= '0;
    end else begin
      if (cmd.load_seed) begin
        gen_a <= start[scl_pkg::GEN_W-1:0];
      end else if (cmd.commit_a) begin
        gen_a <= rem_a;
      end
      if (cmd.derive_b) begin
        gen_b <= (gen_a >= scl_pkg::GEN_W'(scl_pkg::MOD_B))
               ? gen_a - scl_pkg::GEN_W'(scl_pkg::MOD_B) : gen_a;
      end else if (cmd.commit_b) begin
        gen_b <= rem_b;
      end
      if (cmd.derive_c) begin
        gen_c <= (gen_a >= scl_pkg::GEN_W'(scl_pkg::MOD_C))
               ? gen_a - scl_pkg::GEN_W'(scl_pkg::MOD_C) : gen_a;
      end else if (cmd.commit_c) begin
        gen_c <= rem_c;
      end
    end
  end

  // deviate = gen_a * MOD_B + gen_b
  always_ff @(posedge clk) begin
    dev <= scl_pkg::DEV_W'(gen_a) * scl_pkg::DEV_W'(scl_pkg::MOD_B)
         + scl_pkg::DEV_W'(gen_b);
  end

  // table index
  always_ff @(posedge clk) begin
    if (cmd.commit_idx) begin
      idx <= quo_i[IDX_W-1:0];
    end
  end

  // fill counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (cmd.derive_c) begin
      fill_cnt <= '0;
    end else if (cmd.fill_write) begin
      fill_cnt <= fill_cnt + IDX_W'(1);
    end
  end

  assign status.fill_last = (fill_cnt == IDX_W'(TABLE_DEPTH - 1));

  // shuffle table: read-first, one write port
  assign wr_en   = cmd.fill_write | cmd.access;
  assign wr_addr = cmd.access ? idx : fill_cnt;

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      dev_data <= mem[idx];
    end
    if (wr_en) begin
      mem[wr_addr] <= dev;
    end
  end

endmodule

FILE: rtl/core/scl_ctrl.sv
// ----------------------------------------------------------------------------
// scl_ctrl: controller of the shuffled combined LCG
// Sequences seeding, table fill and draws, owns the request and result
// handshakes and the seeded flag.
// ----------------------------------------------------------------------------
module scl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_draw,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scl_pkg::dp_cmd_t     cmd,
  input  scl_pkg::dp_status_t  status
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_SEED     = 15'h0002,
    S_MUL      = 15'h0004,
    S_QUO      = 15'h0008,
    S_SUB      = 15'h0010,
    S_FIX      = 15'h0020,
    S_DERIVE_B = 15'h0040,
    S_DERIVE_C = 15'h0080,
    S_DEV      = 15'h0100,
    S_FILL     = 15'h0200,
    S_IMUL     = 15'h0400,
    S_IQUO     = 15'h0800,
    S_ISUB     = 15'h1000,
    S_IFIX     = 15'h2000,
    S_ACCESS   = 15'h4000
  } state_t;

  // which step sequence the shared generator pass belongs to
  typedef enum logic [3:0] {
    PH_INIT1 = 4'b0001,
    PH_INIT2 = 4'b0010,
    PH_FILL  = 4'b0100,
    PH_DRAW  = 4'b1000
  } phase_t;

  state_t state;
  state_t state_next;
  phase_t phase;
  phase_t phase_next;
  logic   seeded;
  logic   seeded_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    seeded_next    = seeded;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_draw) begin
          if (seeded) begin
            phase_next = PH_DRAW;
            state_next = S_MUL;
          end else begin
            state_next = S_SEED;
          end
        end
      end
      S_SEED: begin
        cmd.load_seed = 1'b1;
        phase_next    = PH_INIT1;
        state_next    = S_MUL;
      end
      S_MUL: state_next = S_QUO;
      S_QUO: state_next = S_SUB;
      S_SUB: state_next = S_FIX;
      S_FIX: begin
        unique case (phase)
          PH_INIT1: begin
            cmd.commit_a = 1'b1;
            state_next   = S_DERIVE_B;
          end
          PH_INIT2: begin
            cmd.commit_a = 1'b1;
            state_next   = S_DERIVE_C;
          end
          PH_FILL: begin
            cmd.commit_a = 1'b1;
            cmd.commit_b = 1'b1;
            state_next   = S_DEV;
          end
          PH_DRAW: begin
            cmd.commit_a = 1'b1;
            cmd.commit_b = 1'b1;
            cmd.commit_c = 1'b1;
            state_next   = S_IMUL;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DERIVE_B: begin
        cmd.derive_b = 1'b1;
        phase_next   = PH_INIT2;
        state_next   = S_MUL;
      end
      S_DERIVE_C: begin
        cmd.derive_c = 1'b1;
        phase_next   = PH_FILL;
        state_next   = S_MUL;
      end
      S_DEV: state_next = S_FILL;
      S_FILL: begin
        cmd.fill_write = 1'b1;
        state_next     = S_MUL;
        if (status.fill_last) begin
          seeded_next = 1'b1;
          phase_next  = PH_DRAW;
        end
      end
      S_IMUL: state_next = S_IQUO;
      S_IQUO: state_next = S_ISUB;
      S_ISUB: state_next = S_IFIX;
      // corrected quotient is ready once the remainder has been registered
      S_IFIX: begin
        cmd.commit_idx = 1'b1;
        state_next     = S_ACCESS;
      end
      S_ACCESS: begin
        // swap only once the result register is free
        if (!out_valid || out_ready) begin
          cmd.access     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_INIT1;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      seeded    <= seeded_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/core/shuffled_combined_lcg_uniform.sv
// A draw runs the modular reduction pass once for the generator step and once
// for the table index, then swaps a table entry into the result register when
// that register is free; no new request is taken until the draw is done.
// The first draw after reset also seeds the generators and fills the table.
// Reset (sync, high) clears seed, generators, controller; table is refilled.
// ----------------------------------------------------------------------------
// shuffled_combined_lcg_uniform: shuffled combined LCG uniform generator
// Three constant-modulus LCGs, two forming each deviate and one picking
// an entry of the shuffle table, which returns and replaces that entry.
// ----------------------------------------------------------------------------
module shuffled_combined_lcg_uniform #(
  parameter int unsigned TABLE_DEPTH = scl_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  scl_req_if.sink    req,
  scl_dev_if.source  result,
  scl_cfg_if.sink    cfg
);

  scl_pkg::dp_cmd_t    cmd;
  scl_pkg::dp_status_t status;

  // seed register always takes a word
  assign cfg.ready = 1'b1;

  scl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_draw   (req.draw_request),
    .in_ready  (req.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  scl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_seed (cfg.seed),
    .cmd      (cmd),
    .status   (status),
    .dev_data (result.deviate_numerator)
  );

  // a new result only follows a table access
  a_result_from_access: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.access))
    else $error("result raised without table access");

  // table access never overwrites a pending result
  a_access_free: assert property (@(posedge clk) disable iff (rst)
    cmd.access |-> (!result.valid || result.ready))
    else $error("table access with result still pending");

  // fill writes and draw accesses are exclusive
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fill_write && cmd.access))
    else $error("fill write and draw access together");

  // an accepted draw makes the block busy
  a_busy_after_draw: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.draw_request) |=> !req.ready)
    else $error("request taken while a draw is in progress");

endmodule
